// ----- rtl/owbm_pkg.sv -----
// ----------------------------------------------------------------------------
// One-wire bus master package
// Command codes, phase codes, slot timing constants and shared types.
// ----------------------------------------------------------------------------
package owbm_pkg;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_RESET = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   localparam int PHASE_W = 4;
   localparam int MICRO_W = 10;
   localparam int PRESC_W = 8;
   localparam int BITIX_W = 4;

   localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
   localparam logic [PHASE_W-1:0] PH_RST_LOW  = 4'd1;
   localparam logic [PHASE_W-1:0] PH_RST_WAIT = 4'd2;
   localparam logic [PHASE_W-1:0] PH_RST_REC  = 4'd3;
   localparam logic [PHASE_W-1:0] PH_WR_LOW   = 4'd4;
   localparam logic [PHASE_W-1:0] PH_WR_HIGH  = 4'd5;
   localparam logic [PHASE_W-1:0] PH_RD_LOW   = 4'd6;
   localparam logic [PHASE_W-1:0] PH_RD_WAIT  = 4'd7;
   localparam logic [PHASE_W-1:0] PH_RD_REC   = 4'd8;

   localparam logic [MICRO_W-1:0] T_RST_LOW   = 10'd480;
   localparam logic [MICRO_W-1:0] T_RST_WAIT  = 10'd70;
   localparam logic [MICRO_W-1:0] T_RST_REC   = 10'd410;
   localparam logic [MICRO_W-1:0] T_WR1_LOW   = 10'd10;
   localparam logic [MICRO_W-1:0] T_WR1_HIGH  = 10'd55;
   localparam logic [MICRO_W-1:0] T_WR0_LOW   = 10'd65;
   localparam logic [MICRO_W-1:0] T_WR0_HIGH  = 10'd5;
   localparam logic [MICRO_W-1:0] T_RD_LOW    = 10'd3;
   localparam logic [MICRO_W-1:0] T_RD_WAIT   = 10'd10;
   localparam logic [MICRO_W-1:0] T_RD_REC    = 10'd53;
   localparam logic [MICRO_W-1:0] T_DEFAULT   = 10'd1;

   localparam logic [BITIX_W-1:0] BITS_PER_BYTE = 4'd8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_TICK_DIVIDER = 1'b0;
   localparam logic [7:0] TICK_DIVIDER_RESET = 8'd1;

   typedef struct packed {
      logic [7:0] tick_divider;
   } cfg_type;

   function automatic logic [MICRO_W-1:0] phase_length(input logic [PHASE_W-1:0] phase,
                                                       input logic one);
      logic [MICRO_W-1:0] len;
      unique case (phase)
         PH_RST_LOW:  len = T_RST_LOW;
         PH_RST_WAIT: len = T_RST_WAIT;
         PH_RST_REC:  len = T_RST_REC;
         PH_WR_LOW:   len = one ? T_WR1_LOW : T_WR0_LOW;
         PH_WR_HIGH:  len = one ? T_WR1_HIGH : T_WR0_HIGH;
         PH_RD_LOW:   len = T_RD_LOW;
         PH_RD_WAIT:  len = T_RD_WAIT;
         PH_RD_REC:   len = T_RD_REC;
         default:     len = T_DEFAULT;
      endcase
      return len;
   endfunction

endpackage

// ----- rtl/owbm_req_if.sv -----
// ----------------------------------------------------------------------------
// One-wire bus master command channel
// Valid/ready channel that carries one command or tick beat.
// ----------------------------------------------------------------------------
interface owbm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic       bus_level;

   modport source (output valid, output kind, output data_byte, output bus_level,
                   input ready);
   modport sink (input valid, input kind, input data_byte, input bus_level,
                 output ready);
endinterface

// ----- rtl/owbm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// One-wire bus master result channel
// Valid/ready channel that carries one status beat per command beat.
// ----------------------------------------------------------------------------
interface owbm_rsp_if;
   logic       valid;
   logic       ready;
   logic       bus_low;
   logic       busy_res;
   logic       done_res;
   logic       presence;
   logic [7:0] read_data;
   logic       rejected;

   modport source (output valid, output bus_low, output busy_res, output done_res,
                   output presence, output read_data, output rejected, input ready);
   modport sink (input valid, input bus_low, input busy_res, input done_res,
                 input presence, input read_data, input rejected, output ready);
endinterface

// ----- rtl/owbm_csr.sv -----
// ----------------------------------------------------------------------------
// One-wire bus master register block
// APB-style port holding the tick divider register.
// ----------------------------------------------------------------------------
module owbm_csr
   import owbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [7:0] tick_divider_ff;
   logic [7:0] tick_divider_in;
   logic       wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[CSR_ADDR_W-1] == REG_TICK_DIVIDER);
   assign tick_divider_in = wr_hit ? csr_pwdata[7:0] : tick_divider_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_divider_ff <= TICK_DIVIDER_RESET;
      end else begin
         tick_divider_ff <= tick_divider_in;
      end
   end

   always_comb begin
      if (csr_paddr[CSR_ADDR_W-1] == REG_TICK_DIVIDER) begin
         csr_prdata = {{(CSR_DATA_W-8){1'b0}}, tick_divider_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   assign cfg.tick_divider = tick_divider_ff;

endmodule

// ----- rtl/one_wire_bus_master_unit.sv -----
// ----------------------------------------------------------------------------
// One-wire bus master, standard speed
// Runs reset/presence, write byte and read byte sequences on tick beats.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake            Payload
//   req_chan  in         valid/ready          kind, data_byte, bus_level
//   rsp_chan  out        valid/ready          bus_low, busy_res, done_res,
//                                             presence, read_data, rejected
//   csr_*     in         APB write, pready=1  tick_divider at byte address 0
//
// Each command beat is handled at the accepting edge, where the sequencer
// state and the result register both update, so one beat per cycle is
// sustained while the result channel is ready, limited only by the single result register.
// A new beat is taken while the result register is empty or being drained.
// Reset is synchronous and clears the sequencer and the result valid flag.
// ----------------------------------------------------------------------------
module one_wire_bus_master_unit
   import owbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   owbm_req_if.sink              req_chan,
   owbm_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [MICRO_W-1:0] micro_ff, micro_in;
   logic [PRESC_W-1:0] presc_ff, presc_in;
   logic [7:0]         shift_ff, shift_in;
   logic [BITIX_W-1:0] bitix_ff, bitix_in;
   logic               presence_ff, presence_in;
   logic [7:0]         last_read_ff, last_read_in;

   logic               rsp_valid_ff;
   logic               bus_low_ff, bus_low_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               rejected_ff, rejected_in;

   logic               accept;
   logic [PRESC_W-1:0] divider;
   logic [PRESC_W-1:0] presc_inc;
   logic [MICRO_W-1:0] micro_inc;
   logic [BITIX_W-1:0] bitix_inc;

   owbm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;

   assign divider   = (cfg.tick_divider == '0) ? PRESC_W'(1) : cfg.tick_divider;
   assign presc_inc = presc_ff + PRESC_W'(1);
   assign micro_inc = micro_ff + MICRO_W'(1);
   assign bitix_inc = bitix_ff + BITIX_W'(1);

   always_comb begin
      phase_in     = phase_ff;
      micro_in     = micro_ff;
      presc_in     = presc_ff;
      shift_in     = shift_ff;
      bitix_in     = bitix_ff;
      presence_in  = presence_ff;
      last_read_in = last_read_ff;
      done_in      = 1'b0;
      rejected_in  = 1'b0;
      if (req_chan.kind != KIND_TICK) begin
         if (phase_ff != PH_IDLE) begin
            rejected_in = 1'b1;
         end else begin
            micro_in = '0;
            presc_in = '0;
            bitix_in = '0;
            unique case (req_chan.kind)
               KIND_RESET: begin
                  phase_in = PH_RST_LOW;
               end
               KIND_WRITE: begin
                  shift_in = req_chan.data_byte;
                  phase_in = PH_WR_LOW;
               end
               default: begin
                  shift_in = '0;
                  phase_in = PH_RD_LOW;
               end
            endcase
         end
      end else if (phase_ff != PH_IDLE) begin
         presc_in = presc_inc;
         if (presc_inc >= divider) begin
            presc_in = '0;
            micro_in = micro_inc;
            if (micro_inc >= phase_length(phase_ff, shift_ff[0])) begin
               micro_in = '0;
               unique case (phase_ff)
                  PH_RST_LOW: begin
                     phase_in = PH_RST_WAIT;
                  end
                  PH_RST_WAIT: begin
                     presence_in = !req_chan.bus_level;
                     phase_in    = PH_RST_REC;
                  end
                  PH_RST_REC: begin
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                  end
                  PH_WR_LOW: begin
                     phase_in = PH_WR_HIGH;
                  end
                  PH_WR_HIGH: begin
                     shift_in = {1'b0, shift_ff[7:1]};
                     bitix_in = bitix_inc;
                     if (bitix_inc >= BITS_PER_BYTE) begin
                        phase_in = PH_IDLE;
                        done_in  = 1'b1;
                     end else begin
                        phase_in = PH_WR_LOW;
                     end
                  end
                  PH_RD_LOW: begin
                     phase_in = PH_RD_WAIT;
                  end
                  PH_RD_WAIT: begin
                     shift_in = {req_chan.bus_level, shift_ff[7:1]};
                     phase_in = PH_RD_REC;
                  end
                  PH_RD_REC: begin
                     bitix_in = bitix_inc;
                     if (bitix_inc >= BITS_PER_BYTE) begin
                        last_read_in = shift_ff;
                        phase_in     = PH_IDLE;
                        done_in      = 1'b1;
                     end else begin
                        phase_in = PH_RD_LOW;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
      end
      bus_low_in = (phase_in == PH_RST_LOW) || (phase_in == PH_WR_LOW)
                   || (phase_in == PH_RD_LOW);
      busy_in    = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         micro_ff     <= '0;
         presc_ff     <= '0;
         shift_ff     <= '0;
         bitix_ff     <= '0;
         presence_ff  <= 1'b0;
         last_read_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            micro_ff     <= micro_in;
            presc_ff     <= presc_in;
            shift_ff     <= shift_in;
            bitix_ff     <= bitix_in;
            presence_ff  <= presence_in;
            last_read_ff <= last_read_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bus_low_ff  <= bus_low_in;
         busy_ff     <= busy_in;
         done_ff     <= done_in;
         rejected_ff <= rejected_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.bus_low   = bus_low_ff;
   assign rsp_chan.busy_res  = busy_ff;
   assign rsp_chan.done_res  = done_ff;
   assign rsp_chan.presence  = presence_ff;
   assign rsp_chan.read_data = last_read_ff;
   assign rsp_chan.rejected  = rejected_ff;

   ast_low_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && bus_low_ff |-> busy_ff)
      else $error("bus driven low while not busy");

   ast_done_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> !busy_ff && !rejected_ff)
      else $error("finished operation still busy or rejected");

   ast_reject_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rejected_ff |-> busy_ff)
      else $error("command rejected while idle");

   ast_idle_clear : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> micro_ff == '0 && presc_ff == '0)
      else $error("idle sequencer holds stale timing counts");

   ast_hold_stall : assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(phase_ff) && $stable(micro_ff))
      else $error("sequencer moved without an accepted beat");

endmodule
